[rtl/scrm_pkg.sv]
// Shared constants, item types and command types for the stereo corner rotation match unit.
package scrm_pkg;

	localparam int MAX_CORNERS = 16;
	localparam int IDX_W       = $clog2(MAX_CORNERS);
	localparam int CNT_W       = $clog2(MAX_CORNERS + 1);
	localparam int COORD_W     = 16;
	localparam int SCORE_W     = 20;
	localparam int OFFSET_W    = 4;
	localparam int SUM_RAW_W   = COORD_W + CNT_W;
	localparam int SUM_W       = (SUM_RAW_W > SCORE_W) ? SUM_RAW_W : SCORE_W + 1;
	localparam int OFF_EXT_W   = (IDX_W > OFFSET_W) ? IDX_W : OFFSET_W;
	localparam int CMD_DEPTH   = 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [COORD_W-1:0]   MAX_GAP_RESET  = 16'd160;
	localparam logic [COORD_W-1:0]   MIN_DISP_RESET = 16'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISP   = 1'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] left_x;
		logic signed [COORD_W-1:0] left_y;
		logic signed [COORD_W-1:0] right_x;
		logic signed [COORD_W-1:0] right_y;
		logic                      last;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] best_offset;
		logic [SCORE_W-1:0]  score;
		logic                overflow;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0]        max_vertical_gap;
		logic signed [COORD_W-1:0] disp_limit;
	} cfg_t;

	typedef struct packed {
		logic                      store_en;
		logic [IDX_W-1:0]          addr;
		logic signed [COORD_W-1:0] left_x;
		logic signed [COORD_W-1:0] left_y;
		logic signed [COORD_W-1:0] right_x;
		logic signed [COORD_W-1:0] right_y;
		logic                      search;
		logic [CNT_W-1:0]          n;
		logic                      overflow;
	} cmd_t;

endpackage

[rtl/scrm_front.sv]
// Front end: accepts corner pairs, counts them and turns each into a store or search command.
module scrm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  scrm_pkg::in_item_t item,
	output logic             full,
	input  logic             cmd_full,
	output logic             cmd_push,
	output scrm_pkg::cmd_t   cmd
);
	import scrm_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             room;

	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full;
	assign room     = count_q < CNT_W'(MAX_CORNERS);

	always_comb begin
		cmd.store_en = room;
		cmd.addr     = count_q[IDX_W-1:0];
		cmd.left_x   = item.left_x;
		cmd.left_y   = item.left_y;
		cmd.right_x  = item.right_x;
		cmd.right_y  = item.right_y;
		cmd.search   = item.last;
		cmd.n        = room ? count_q + CNT_W'(1) : count_q;
		cmd.overflow = ovf_q || !room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd_push) begin
			if (item.last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= cmd.n;
				ovf_q   <= cmd.overflow;
			end
		end
	end

endmodule

[rtl/scrm_cmd_fifo.sv]
// Short command queue between the front end and the search engine.
module scrm_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  scrm_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd,
	output scrm_pkg::cmd_t rd_data,
	output logic           empty
);
	import scrm_pkg::*;

	localparam int PTR_W = $clog2(CMD_DEPTH);
	localparam int FILL_W = $clog2(CMD_DEPTH + 1);

	cmd_t              mem_q [CMD_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = fill_q == FILL_W'(CMD_DEPTH);
	assign empty   = fill_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

[rtl/scrm_back.sv]
// Back end: corner stores, the offset search pipeline and the result register.
module scrm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  scrm_pkg::cfg_t      cfg,
	input  logic                cmd_empty,
	input  scrm_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output scrm_pkg::out_item_t result
);
	import scrm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;

	logic [2*COORD_W-1:0] lmem [MAX_CORNERS];
	logic [2*COORD_W-1:0] rmem [MAX_CORNERS];

	logic [CNT_W-1:0] n_q;
	logic             ovf_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] offs_q;
	logic             last_i;
	logic             last_off;
	logic             issue;

	logic                 v_s1;
	logic                 first_s1;
	logic                 endc_s1;
	logic [IDX_W-1:0]     offs_s1;
	logic [2*COORD_W-1:0] l_rd_s1;
	logic [2*COORD_W-1:0] r_rd_s1;

	logic                      v_s2;
	logic                      first_s2;
	logic                      endc_s2;
	logic [IDX_W-1:0]          offs_s2;
	logic [COORD_W-1:0]        gap_s2;
	logic signed [COORD_W:0]   dx_s2;

	logic                    done_s3;
	logic [IDX_W-1:0]        offs_s3;
	logic [SUM_W-1:0]        sum_q;
	logic [COORD_W-1:0]      gmax_q;
	logic signed [COORD_W:0] dmin_q;

	logic                    found_q;
	logic [SUM_W-1:0]        best_sum_q;
	logic [IDX_W-1:0]        best_offs_q;

	logic                    res_valid_q;
	out_item_t               res_q;
	logic                    res_load;

	logic signed [COORD_W:0] dy;
	logic signed [COORD_W:0] dx;
	logic [COORD_W-1:0]      gap;
	logic                    accept;
	logic [OFF_EXT_W-1:0]    off_ext;

	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign last_i   = CNT_W'(i_q) == n_q - CNT_W'(1);
	assign last_off = CNT_W'(offs_q) == n_q - CNT_W'(1);
	assign issue    = state_q == ST_RUN;
	assign res_load = (state_q == ST_DRAIN) && !v_s1 && !v_s2 && !done_s3 &&
		(!res_valid_q || pop);
	assign empty    = !res_valid_q;
	assign result   = res_q;

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.store_en) begin
			lmem[cmd.addr] <= {cmd.left_y, cmd.left_x};
			rmem[cmd.addr] <= {cmd.right_y, cmd.right_x};
		end
		l_rd_s1 <= lmem[i_q];
		r_rd_s1 <= rmem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			offs_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.search) begin
						n_q     <= cmd.n;
						ovf_q   <= cmd.overflow;
						i_q     <= '0;
						j_q     <= '0;
						offs_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_i) begin
						i_q    <= '0;
						offs_q <= offs_q + IDX_W'(1);
						j_q    <= offs_q + IDX_W'(1);
						if (last_off) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						i_q <= i_q + IDX_W'(1);
						j_q <= (CNT_W'(j_q) == n_q - CNT_W'(1)) ? '0 : j_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		dy  = {l_rd_s1[2*COORD_W-1], l_rd_s1[2*COORD_W-1:COORD_W]} -
			{r_rd_s1[2*COORD_W-1], r_rd_s1[2*COORD_W-1:COORD_W]};
		dx  = {l_rd_s1[COORD_W-1], l_rd_s1[COORD_W-1:0]} -
			{r_rd_s1[COORD_W-1], r_rd_s1[COORD_W-1:0]};
		gap = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= issue;
			v_s2    <= v_s1;
			done_s3 <= v_s2 && endc_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= i_q == '0;
		endc_s1  <= last_i;
		offs_s1  <= offs_q;
		first_s2 <= first_s1;
		endc_s2  <= endc_s1;
		offs_s2  <= offs_s1;
		gap_s2   <= gap;
		dx_s2    <= dx;
		offs_s3  <= offs_s2;
		if (v_s2) begin
			if (first_s2) begin
				sum_q  <= SUM_W'(gap_s2);
				gmax_q <= gap_s2;
				dmin_q <= dx_s2;
			end else begin
				sum_q  <= sum_q + SUM_W'(gap_s2);
				gmax_q <= (gap_s2 > gmax_q) ? gap_s2 : gmax_q;
				dmin_q <= (dx_s2 < dmin_q) ? dx_s2 : dmin_q;
			end
		end
	end

	assign accept = (gmax_q < cfg.max_vertical_gap) &&
		(dmin_q > $signed({cfg.disp_limit[COORD_W-1], cfg.disp_limit}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd_pop && cmd.search) begin
			found_q <= 1'b0;
		end else if (done_s3 && accept && (!found_q || sum_q < best_sum_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s3 && accept && (!found_q || sum_q < best_sum_q)) begin
			best_sum_q  <= sum_q;
			best_offs_q <= offs_s3;
		end
	end

	assign off_ext = OFF_EXT_W'(best_offs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.found       <= found_q;
			res_q.best_offset <= found_q ? off_ext[OFFSET_W-1:0] : '0;
			if (!found_q || best_sum_q[SUM_W-1:SCORE_W] != '0) begin
				res_q.score <= '1;
			end else begin
				res_q.score <= best_sum_q[SCORE_W-1:0];
			end
			res_q.overflow <= ovf_q;
		end
	end

`ifndef SYNTHESIS
	a_issue_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == ST_RUN))
		else $error("A corner read was issued outside the search.");
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (CNT_W'(i_q) < n_q && CNT_W'(j_q) < n_q))
		else $error("A corner index ran past the stored corners.");
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_valid_q || pop))
		else $error("A waiting result item was overwritten.");
	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (!v_s1 && !v_s2 && !done_s3))
		else $error("The search pipeline was busy after the result was taken.");
`endif

endmodule

[rtl/stereo_corner_rotation_match_unit.sv]
// Top level of the stereo corner rotation match unit.
//
// Input queue: an item is one left and right corner pair in Q12.4; it is taken
// when push is high and full is low. Pairs are stored in arrival order until
// the item marked last, which starts the search over every cyclic offset.
// Result queue: while empty is low the result item waits on result and is taken
// when pop is high. One result item follows each last-marked item.
// Configuration: cfg_index selects the vertical gap limit (0) or the disparity
// floor (1); a write is taken when cfg_valid and cfg_ready are high; cfg_ready
// is always high.
// Throughput: the search engine takes stored pairs from the command queue only
// while it is idle. A search over n corners issues n*n corner reads, one per
// cycle from the corner memories, then drains the search pipeline and loads the
// result register. The two-entry command queue lets the front take pairs of the
// next polygon while a search runs.
// Reset clears the corner count, the queues and the result, and loads the
// registers with 160 and 0. If pop stays low a finished result holds; the
// engine then stops before its next result and the input queue fills.
module stereo_corner_rotation_match_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  scrm_pkg::in_item_t                  item,
	output logic                                full,
	output logic                                empty,
	input  logic                                pop,
	output scrm_pkg::out_item_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [scrm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scrm_pkg::COORD_W-1:0]        cfg_data
);
	import scrm_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_vertical_gap <= MAX_GAP_RESET;
			cfg_q.disp_limit       <= MIN_DISP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_GAP:  cfg_q.max_vertical_gap <= cfg_data;
				REG_MIN_DISP: cfg_q.disp_limit       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	scrm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	scrm_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd      (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	scrm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

[test/tb_top.sv]
// Self-checking testbench for the stereo corner rotation match unit, with its own search model.
module tb_top;
	import scrm_pkg::*;

	localparam int SEARCH_WAIT = MAX_CORNERS * MAX_CORNERS + MAX_CORNERS + 40;
	localparam int IDLE_PERCENT = 16;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	in_item_t             item = '0;
	logic                 full;
	logic                 empty;
	logic                 pop = 1'b0;
	out_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_GAP;
	logic [COORD_W-1:0]   cfg_data = '0;

	logic signed [COORD_W-1:0] lx_store [MAX_CORNERS];
	logic signed [COORD_W-1:0] ly_store [MAX_CORNERS];
	logic signed [COORD_W-1:0] rx_store [MAX_CORNERS];
	logic signed [COORD_W-1:0] ry_store [MAX_CORNERS];
	int        stored_pairs = 0;
	bit        pairs_dropped = 1'b0;
	int        gap_limit = MAX_GAP_RESET;
	int        disp_floor = 0;
	out_item_t expected_matches [$];

	int error_count = 0;
	int results_checked = 0;
	int polygons_sent = 0;
	int pairs_sent = 0;
	int register_writes = 0;
	int hold_request = 0;
	int hold_left = 0;
	bit steady = 1'b0;

	always #1 clk = ~clk;

	stereo_corner_rotation_match_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	function automatic out_item_t rotation_search();
		out_item_t r;
		longint    sum;
		longint    best_sum;
		int        best_off;
		int        off;
		int        i;
		int        j;
		int        dy;
		int        dx;
		int        gap;
		int        gap_max;
		int        disp_min;
		bit        hit;
		best_sum = 0;
		best_off = 0;
		hit = 1'b0;
		for (off = 0; off < stored_pairs; off++) begin
			sum = 0;
			gap_max = 0;
			disp_min = 32'h7fffffff;
			for (i = 0; i < stored_pairs; i++) begin
				j = (i + off) % stored_pairs;
				dy = ly_store[i] - ry_store[j];
				gap = (dy < 0) ? -dy : dy;
				sum += gap;
				if (gap > gap_max)
					gap_max = gap;
				dx = lx_store[i] - rx_store[j];
				if (dx < disp_min)
					disp_min = dx;
			end
			if (gap_max < gap_limit && disp_min > disp_floor && (!hit || sum < best_sum)) begin
				hit = 1'b1;
				best_sum = sum;
				best_off = off;
			end
		end
		r.found = hit;
		r.best_offset = hit ? OFFSET_W'(best_off) : '0;
		if (!hit || best_sum > longint'({SCORE_W{1'b1}}))
			r.score = '1;
		else
			r.score = SCORE_W'(best_sum);
		r.overflow = pairs_dropped;
		return r;
	endfunction

	function automatic void record_pair(input in_item_t it);
		pairs_sent++;
		if (stored_pairs < MAX_CORNERS) begin
			lx_store[stored_pairs] = it.left_x;
			ly_store[stored_pairs] = it.left_y;
			rx_store[stored_pairs] = it.right_x;
			ry_store[stored_pairs] = it.right_y;
			stored_pairs++;
		end else begin
			pairs_dropped = 1'b1;
		end
		if (it.last) begin
			expected_matches = {expected_matches, rotation_search()};
			stored_pairs = 0;
			pairs_dropped = 1'b0;
		end
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	function automatic in_item_t make_pair(input int lx, input int ly, input int rx, input int ry,
		input bit last);
		in_item_t it;
		it.left_x = COORD_W'(lx);
		it.left_y = COORD_W'(ly);
		it.right_x = COORD_W'(rx);
		it.right_y = COORD_W'(ry);
		it.last = last;
		return it;
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(8, 1);
		else if (r < 94)
			return $urandom_range(MAX_CORNERS, 9);
		return $urandom_range(MAX_CORNERS + 4, MAX_CORNERS + 1);
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_matches.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				error_count++;
			end else begin
				want = expected_matches.pop_front();
				results_checked++;
				check_field("found", want.found, result.found);
				check_field("best_offset", want.best_offset, result.best_offset);
				check_field("score", want.score, result.score);
				check_field("overflow", want.overflow, result.overflow);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	task automatic send_pair(input in_item_t it);
		int gap;
		item <= it;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full !== 1'b0);
		record_pair(it);
		@(negedge clk);
		if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			gap = $urandom_range(4, 1);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic sender_rest();
		push <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_for_results(input int settle);
		while (expected_matches.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		if (idx == REG_MAX_GAP)
			gap_limit = value;
		else
			disp_floor = $signed(value);
		register_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input int gap, input int disp);
		sender_rest();
		wait_for_results(SEARCH_WAIT);
		write_register(REG_MAX_GAP, COORD_W'(gap));
		write_register(REG_MIN_DISP, COORD_W'(disp));
	endtask

	task automatic send_polygon(input int n_pairs, input bit aligned);
		int lx [MAX_CORNERS + 8];
		int ly [MAX_CORNERS + 8];
		int used;
		int rot;
		int disp;
		int src;
		int k;
		in_item_t it;
		used = (n_pairs < MAX_CORNERS) ? n_pairs : MAX_CORNERS;
		rot = $urandom_range(used - 1);
		disp = $urandom_range(3000);
		for (k = 0; k < n_pairs; k++) begin
			lx[k] = int'($urandom_range(32000)) - 16000;
			ly[k] = int'($urandom_range(32000)) - 16000;
		end
		for (k = 0; k < n_pairs; k++) begin
			if (aligned && k < used) begin
				src = (k - rot + used) % used;
				it = make_pair(lx[k], ly[k], lx[src] - disp - int'($urandom_range(50)),
					ly[src] + int'($urandom_range(200)) - 100, 1'b0);
			end else begin
				it = make_pair($urandom, $urandom, $urandom, $urandom, 1'b0);
			end
			it.last = (k == n_pairs - 1);
			send_pair(it);
		end
		polygons_sent++;
	endtask

	task automatic test_directed_polygons();
		int k;
		send_pair(make_pair(1600, 320, 800, 300, 1'b1));
		send_pair(make_pair(2000, 0, 1000, 1600, 1'b0));
		send_pair(make_pair(2000, 800, 1000, 0, 1'b0));
		send_pair(make_pair(2000, 1600, 1000, 800, 1'b1));
		send_pair(make_pair(32767, -32768, -32768, 32767, 1'b0));
		send_pair(make_pair(-32768, 32767, 32767, -32768, 1'b1));
		send_pair(make_pair(100, 0, 0, 0, 1'b0));
		send_pair(make_pair(100, 0, 0, 0, 1'b1));
		// Seventeen pairs: the one marked last is dropped and the result flags the overflow.
		for (k = 0; k <= MAX_CORNERS; k++)
			send_pair(make_pair(k * 64, k * 16, k * 64 - 10, k * 16, k == MAX_CORNERS));
		polygons_sent += 5;
		sender_rest();
		wait_for_results(0);
	endtask

	task automatic test_result_backpressure();
		int k;
		hold_request = 1500;
		for (k = 0; k < 8; k++)
			send_polygon(5, 1'b1);
		sender_rest();
		wait_for_results(0);
	endtask

	task automatic test_random_polygons();
		int gap_set [6] = '{160, 65535, 0, 400, 1, -1};
		int disp_set [6] = '{0, -32768, 32767, -200, 1000, -1};
		int chunk;
		int target;
		int gap;
		int disp;
		bit paused;
		for (chunk = 0; chunk < 6; chunk++) begin
			gap = (gap_set[chunk] < 0) ? int'($urandom_range(65535)) : gap_set[chunk];
			disp = (disp_set[chunk] < 0) ? int'($urandom_range(65535)) - 32768 : disp_set[chunk];
			configure(gap, disp);
			steady = (chunk == 2);
			target = pairs_sent + 300;
			paused = 1'b0;
			while (pairs_sent < target) begin
				send_polygon(pick_size(), $urandom_range(99) < 75);
				if (!paused && pairs_sent + 150 >= target) begin
					sender_rest();
					wait_for_results(0);
					paused = 1'b1;
				end
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_polygons();
		test_result_backpressure();
		test_random_polygons();
		sender_rest();
		wait_for_results(SEARCH_WAIT);
		$display("Checked %0d results from %0d polygons, %0d corner pairs, %0d register writes.",
			results_checked, polygons_sent, pairs_sent, register_writes);
		$display("Covered rotations, threshold extremes, ties, dropped corners and output stalls.");
		if (error_count == 0 && expected_matches.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
rtl/scrm_pkg.sv
rtl/scrm_front.sv
rtl/scrm_cmd_fifo.sv
rtl/scrm_back.sv
rtl/stereo_corner_rotation_match_unit.sv
test/tb_top.sv
